### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is asserted.
`define IORB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge out of reset.
`define IORB_NEVER(label, cond, msg) \
    `IORB_ASSERT(label, !(cond), msg)

`endif

### hw/rtl/iorb_pkg.sv
// Package with widths, defaults and controller/datapath interface types.
`timescale 1ns / 1ps

package iorb_pkg;

    localparam int ID_W      = 7;
    localparam int VALUE_W   = 40;
    localparam int DEPTH_DEF = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;    // write the accepted item into its slot
        logic load;     // read the slot at the release pointer
        logic advance;  // released item taken, step the pointer
    } iorb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic id_ok;       // incoming id lies within the usable length
        logic head_avail;  // slot at the release pointer is in range and valid
        logic run_last;    // item on the output closes the current run
    } iorb_status_t;

endpackage

### hw/rtl/iorb_ctrl.sv
// Controller state machine sequencing insert, head check and run release.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iorb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  iorb_pkg::iorb_status_t status,
    output iorb_pkg::iorb_cmd_t    cmd
);
    import iorb_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                // An id outside the stream is dropped and the block stays ready.
                if (in_valid && status.id_ok)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.head_avail)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEND;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (status.run_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `IORB_ASSERT(a_send_from_check, (state_reg == S_SEND) && !$past(state_reg == S_SEND) |-> $past(state_reg == S_CHECK), "release run started without a head check")
    `IORB_ASSERT(a_drop_stays_ready, in_valid && in_ready && !status.id_ok |=> in_ready, "ignored item left the block busy")

endmodule

### hw/rtl/iorb_datapath.sv
// Datapath: slot memory, valid bits, release pointer, stream length and output registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iorb_datapath #(
    parameter int DEPTH = iorb_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [iorb_pkg::ID_W-1:0]    cfg_wr_data,
    input  logic [iorb_pkg::ID_W-1:0]    entry_id,
    input  logic [iorb_pkg::VALUE_W-1:0] entry_value,
    input  iorb_pkg::iorb_cmd_t          cmd,
    output iorb_pkg::iorb_status_t       status,
    output logic [iorb_pkg::VALUE_W-1:0] released_value,
    output logic [iorb_pkg::ID_W-1:0]    released_id,
    output logic                        last
);
    import iorb_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [ID_W-1:0]    ptr_reg;
    logic [ID_W-1:0]    len_reg;
    logic               last_reg;

    logic [ID_W-1:0]    len_eff;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   head_idx;
    logic [ID_W-1:0]    pos;
    logic [ID_W-1:0]    after;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   after_idx;
    logic               pos_last;
    logic               rd_en;

    // A length above the depth acts as the depth.
    assign len_eff  = (len_reg > ID_W'(DEPTH)) ? ID_W'(DEPTH) : len_reg;
    assign wr_idx   = IDX_W'(entry_id - ID_W'(1));
    assign head_idx = IDX_W'(ptr_reg - ID_W'(1));

    // Id of the item being fetched: the head on a load, the one after it on an advance.
    assign pos       = cmd.advance ? (ptr_reg + ID_W'(1)) : ptr_reg;
    assign after     = pos + ID_W'(1);
    assign rd_idx    = IDX_W'(pos - ID_W'(1));
    assign after_idx = IDX_W'(pos);
    assign pos_last  = !((after <= len_eff) && valid_reg[after_idx]);
    assign rd_en     = cmd.load || (cmd.advance && !last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= ID_W'(DEPTH);
            valid_reg <= '0;
            ptr_reg   <= ID_W'(1);
            last_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            // A new stream length restarts the stream.
            len_reg   <= cfg_wr_data;
            valid_reg <= '0;
            ptr_reg   <= ID_W'(1);
        end
        else
        begin
            if (cmd.store)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.advance)
            begin
                ptr_reg <= ptr_reg + ID_W'(1);
            end
            if (rd_en)
            begin
                last_reg <= pos_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[wr_idx] <= entry_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign status.id_ok      = (entry_id != '0) && (entry_id <= len_eff);
    assign status.head_avail = (ptr_reg <= len_eff) && valid_reg[head_idx];
    assign status.run_last   = last_reg;

    assign released_value = rd_data_reg;
    assign released_id    = ptr_reg;
    assign last           = last_reg;

    `IORB_ASSERT(a_store_sets_valid, cmd.store && !cfg_wr_en |=> valid_reg[$past(wr_idx)], "stored slot not marked valid")
    `IORB_ASSERT(a_run_continues, cmd.advance && !last_reg && !cfg_wr_en |=> status.head_avail, "run continued onto a slot that is not ready")

endmodule

### hw/rtl/in_order_release_buffer.sv
// Top level of the in-order release buffer: controller plus datapath.
`timescale 1ns / 1ps

// An item carries a one-based id and a 40-bit payload; it is stored in the slot for its id
// and then the longest run of ready slots from the release pointer leaves in id order, one
// result per cycle while out_ready is high, with last on the final one. An item with an id
// outside 1..stream_length (a length above the depth acts as the depth) releases nothing
// and the block stays ready. Any other item is accepted, then head-checked, then releases
// its run; the block takes no new item until that is done. The single read port of the
// slot memory sets the one-result-per-cycle pace of a run. Writing cfg_wr_data with
// cfg_wr_en starts a new stream at once (valid bits cleared, pointer back to one); write it
// only while the block is idle. After reset the stream length is the depth.
module in_order_release_buffer #(
    parameter int DEPTH = iorb_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [iorb_pkg::ID_W-1:0]    cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [iorb_pkg::ID_W-1:0]    entry_id,
    input  logic [iorb_pkg::VALUE_W-1:0] entry_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [iorb_pkg::VALUE_W-1:0] released_value,
    output logic [iorb_pkg::ID_W-1:0]    released_id,
    output logic                        last
);
    import iorb_pkg::*;

    iorb_cmd_t    cmd;
    iorb_status_t status;

    iorb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    iorb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .entry_id       (entry_id),
        .entry_value    (entry_value),
        .cmd            (cmd),
        .status         (status),
        .released_value (released_value),
        .released_id    (released_id),
        .last           (last)
    );

endmodule

### tb/tb_in_order_release_buffer.sv
// Self-checking testbench for the in-order release buffer: random ordered streams against a predictor.
`timescale 1ns / 1ps

module tb_in_order_release_buffer;

    localparam int DEPTH        = iorb_pkg::DEPTH_DEF;
    localparam int ITEM_TARGET  = 170;
    localparam int IDLE_PCT     = 38;
    localparam int LONG_HOLD    = 500;
    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef logic [iorb_pkg::ID_W-1:0]    id_t;
    typedef logic [iorb_pkg::VALUE_W-1:0] value_t;

    typedef struct {
        id_t    id;
        value_t value;
    } entry_item_t;

    typedef struct {
        value_t value;
        id_t    id;
        logic   closes_run;
    } release_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_wr_en = 1'b0;
    id_t    cfg_wr_data = '0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    id_t    entry_id = '0;
    value_t entry_value = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    value_t released_value;
    id_t    released_id;
    logic   last;

    // Shadow copy of the buffer state.
    value_t slot_payload [DEPTH];
    bit     slot_filled [DEPTH];
    int     release_ptr = 1;
    int     stream_len = DEPTH;

    entry_item_t pending_items [$];
    release_t    expected_releases [$];
    entry_item_t next_item;
    release_t    head_release;

    int  queued_total = 0;
    int  accepted_total = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  steady = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;

    in_order_release_buffer #(
        .DEPTH(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .entry_id       (entry_id),
        .entry_value    (entry_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .released_value (released_value),
        .released_id    (released_id),
        .last           (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic int stream_span();
        return (stream_len > DEPTH) ? DEPTH : stream_len;
    endfunction

    // Store the item and work out the run of releases it unlocks.
    task automatic predict_insert(input id_t id, input value_t value);
        int       span;
        release_t rel;
        span = stream_span();
        if (id == 0 || id > span)
            return;
        slot_payload[id - 1] = value;
        slot_filled[id - 1]  = 1'b1;
        while (release_ptr <= span && slot_filled[release_ptr - 1])
        begin
            rel.value = slot_payload[release_ptr - 1];
            rel.id    = id_t'(release_ptr);
            release_ptr++;
            rel.closes_run = !(release_ptr <= span && slot_filled[release_ptr - 1]);
            expected_releases.push_back(rel);
        end
    endtask

    function automatic value_t rand_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        return value_t'({$urandom, $urandom});
    endfunction

    task automatic queue_item(input id_t id, input value_t value);
        entry_item_t item;
        item.id    = id;
        item.value = value;
        pending_items.push_back(item);
        queued_total++;
    endtask

    // Returns once every queued item is taken and every release has come out.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_total != accepted_total || expected_releases.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_stream_length(input int len);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id_t'(len);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        stream_len  = len;
        release_ptr = 1;
        foreach (slot_filled[i])
            slot_filled[i] = 1'b0;
    endtask

    // One stream of ids 1..span, optionally shuffled, with one id missing or
    // with stray items mixed in (repeats, zero, ids past the end).
    task automatic queue_stream(input bit in_order, input bit drop_one, input int noise_pct);
        int  span;
        int  order [$];
        int  pick;
        int  tmp;
        id_t noise_id;
        span = stream_span();
        for (int i = 1; i <= span; i++)
            order.push_back(i);
        if (!in_order)
        begin
            for (int i = span - 1; i > 0; i--)
            begin
                pick     = $urandom_range(i, 0);
                tmp      = order[i];
                order[i] = order[pick];
                order[pick] = tmp;
            end
        end
        if (drop_one && span > 1)
            order.delete($urandom_range(span - 1, 0));
        foreach (order[i])
        begin
            queue_item(id_t'(order[i]), rand_value());
            if ($urandom_range(99) < noise_pct)
            begin
                case ($urandom_range(2))
                    0: noise_id = id_t'(order[$urandom_range(i, 0)]);
                    1: noise_id = '0;
                    default: noise_id = (span < 127) ? id_t'($urandom_range(127, span + 1)) : '0;
                endcase
                queue_item(noise_id, rand_value());
            end
        end
    endtask

    // Sender: holds each item until it is taken, idles at random between items.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_insert(entry_id, entry_value);
                accepted_total++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_item = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    entry_id    <= next_item.id;
                    entry_value <= next_item.value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_ready      <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_releases.size() == 0)
            begin
                report_mismatch($sformatf("id %0d released with nothing expected", released_id));
            end
            else
            begin
                head_release = expected_releases.pop_front();
                if (released_id !== head_release.id)
                    report_mismatch($sformatf("released_id %0d, expected %0d",
                                              released_id, head_release.id));
                if (released_value !== head_release.value)
                    report_mismatch($sformatf("id %0d: released_value %h, expected %h",
                                              head_release.id, released_value,
                                              head_release.value));
                if (last !== head_release.closes_run)
                    report_mismatch($sformatf("id %0d: last %b, expected %b",
                                              head_release.id, last, head_release.closes_run));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d releases outstanding",
                     cycle_count, expected_releases.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int len;
        int roll;
        foreach (slot_filled[i])
            slot_filled[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: out-of-range ids, out-of-order arrival, repeats and overwrites.
        queue_item(7'd0, '1);
        queue_item(7'd127, '1);
        queue_item(7'd65, '1);
        queue_item(7'd2, '1);
        queue_item(7'd1, '0);
        queue_item(7'd3, 40'hAA_AAAA_AAAA);
        queue_item(7'd5, rand_value());
        queue_item(7'd4, rand_value());
        queue_item(7'd2, rand_value());
        queue_item(7'd7, rand_value());
        queue_item(7'd7, '1);
        queue_item(7'd6, 40'h55_5555_5555);
        queue_item(7'd64, rand_value());

        // Shortest non-empty stream, then inserts after it has finished.
        write_stream_length(1);
        queue_item(7'd1, rand_value());
        queue_item(7'd2, rand_value());
        queue_item(7'd1, rand_value());

        // A zero length ignores every id.
        write_stream_length(0);
        queue_item(7'd0, rand_value());
        queue_item(7'd1, rand_value());
        queue_item(7'd64, rand_value());
        queue_item(7'd127, rand_value());

        // Length above the depth, with the receiver stalled long enough to back up the input.
        write_stream_length(127);
        long_hold_req <= 1'b1;
        queue_item(7'd65, rand_value());
        queue_item(7'd100, rand_value());
        queue_stream(1'b1, 1'b0, 0);
        queue_item(7'd64, rand_value());

        // Full-depth shuffled stream with no idling on either side.
        write_stream_length(64);
        steady <= 1'b1;
        queue_stream(1'b0, 1'b0, 0);
        wait_idle();
        steady <= 1'b0;

        while (queued_total < ITEM_TARGET)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                len = $urandom_range(12, 1);
            else if (roll < 85)
                len = $urandom_range(40, 13);
            else if (roll < 90)
                len = 64;
            else if (roll < 95)
                len = $urandom_range(127, 65);
            else
                len = 0;
            // Short final streams keep the run near its item budget.
            if (len > ITEM_TARGET - queued_total)
                len = ITEM_TARGET - queued_total;
            write_stream_length(len);
            if (len == 0)
            begin
                for (int k = 0; k < 4; k++)
                    queue_item(id_t'($urandom_range(127, 0)), rand_value());
            end
            else
            begin
                queue_stream(1'b0, $urandom_range(99) < 15, 15);
                if ($urandom_range(99) < 20)
                    queue_item(id_t'($urandom_range(stream_span(), 1)), rand_value());
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
